// ----- hw/rtl/pmf_pkg.sv -----
package pmf_pkg;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_MAX_DISTANCE  = 2'd0,
      CSR_MAX_HEADING   = 2'd1,
      CSR_MAX_TIME_DIFF = 2'd2
   } csr_index_type;

   localparam int unsigned CSR_ADDR_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [15:0] MAX_DISTANCE_RESET  = 16'd300;
   localparam logic [15:0] MAX_HEADING_RESET   = 16'd3641;
   localparam logic [31:0] MAX_TIME_DIFF_RESET = 32'd9999000;

   // One timed pose: the payload of a request without its restart flag.
   typedef struct packed {
      logic [31:0]        stamp_ms;
      logic signed [23:0] pos_x_mm;
      logic signed [23:0] pos_y_mm;
      logic [15:0]        heading;
   } pose_type;

   // The reference pose together with its valid flag.
   typedef struct packed {
      logic     valid;
      pose_type pose;
   } ref_type;

   // Similarity limits; the distance limit is kept squared.
   typedef struct packed {
      logic [31:0] dist_sq;
      logic [15:0] heading;
      logic [31:0] time_ms;
   } limits_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      logic [31:0] result;
      result = (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
      return result;
   endfunction

endpackage

// ----- hw/rtl/pmf_compare.sv -----
module pmf_compare (
   input  pmf_pkg::pose_type   pose,
   input  pmf_pkg::ref_type    ref_pose,
   input  pmf_pkg::limits_type limits,
   output logic                similar
);
   import pmf_pkg::*;

   logic [31:0] dt;
   logic [24:0] dx;
   logic [24:0] dy;
   logic [24:0] ax;
   logic [24:0] ay;
   logic [31:0] sq_x;
   logic [31:0] sq_y;
   logic [32:0] d2;
   logic        near;
   logic [15:0] dh;
   logic [16:0] adh;
   logic        time_ok;
   logic        dist_ok;
   logic        heading_ok;

   assign dt = pose.stamp_ms - ref_pose.pose.stamp_ms;
   assign time_ok = (dt <= limits.time_ms);

   assign dx = {pose.pos_x_mm[23], pose.pos_x_mm}
             - {ref_pose.pose.pos_x_mm[23], ref_pose.pose.pos_x_mm};
   assign dy = {pose.pos_y_mm[23], pose.pos_y_mm}
             - {ref_pose.pose.pos_y_mm[23], ref_pose.pose.pos_y_mm};
   assign ax = dx[24] ? (~dx + 25'd1) : dx;
   assign ay = dy[24] ? (~dy + 25'd1) : dy;

   // The squared limit is below 2^32, so any offset of 65536 mm or more
   // on either axis is already out of range and only 16-bit squares remain.
   assign near = (ax[24:16] == 9'd0) && (ay[24:16] == 9'd0);
   assign sq_x = {16'd0, ax[15:0]} * {16'd0, ax[15:0]};
   assign sq_y = {16'd0, ay[15:0]} * {16'd0, ay[15:0]};
   assign d2 = {1'b0, sq_x} + {1'b0, sq_y};
   assign dist_ok = near && (d2 <= {1'b0, limits.dist_sq});

   assign dh = pose.heading - ref_pose.pose.heading;
   assign adh = dh[15] ? (17'h1_0000 - {1'b0, dh}) : {1'b0, dh};
   assign heading_ok = (adh <= {1'b0, limits.heading});

   assign similar = ref_pose.valid && time_ok && dist_ok && heading_ok;

endmodule

// ----- hw/rtl/pmf_track.sv -----
module pmf_track (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              restart,
   input  pmf_pkg::pose_type pose,
   input  logic              similar,
   output pmf_pkg::ref_type  ref_pose,
   output logic [31:0]       seen_next,
   output logic [31:0]       kept_next
);
   import pmf_pkg::*;

   logic        ref_valid_ff;
   pose_type    ref_pose_ff;
   logic [31:0] seen_ff;
   logic [31:0] kept_ff;
   logic [31:0] seen_base;
   logic [31:0] kept_base;

   // A restart drops the reference and the counts before the pose is judged.
   assign ref_pose.valid = ref_valid_ff && !restart;
   assign ref_pose.pose  = ref_pose_ff;
   assign seen_base = restart ? 32'd0 : seen_ff;
   assign kept_base = restart ? 32'd0 : kept_ff;
   assign seen_next = sat_inc(seen_base);
   assign kept_next = similar ? kept_base : sat_inc(kept_base);

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_valid_ff <= 1'b0;
         seen_ff      <= 32'd0;
         kept_ff      <= 32'd0;
      end else if (advance) begin
         seen_ff <= seen_next;
         kept_ff <= kept_next;
         if (!similar) begin
            ref_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !similar) begin
         ref_pose_ff <= pose;
      end
   end

endmodule

// ----- hw/rtl/pose_motion_filter.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  restart, stamp_ms, pos_x_mm, pos_y_mm, heading
// rsp_      out        rsp_valid / rsp_ready  similar, seen_count, kept_count
// csr_      in         csr_we                 csr_addr, csr_wdata
//
// A transaction is taken into the input register, judged against the reference
// while it waits there and placed in the result register once that register
// is free. One transaction per cycle is sustained while responses are taken.
// Reset (synchronous, active high) empties both registers, drops the reference
// and restores the register defaults. A stalled response holds the result
// register; the input register keeps taking work as long as it can drain.
module pose_motion_filter (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   input  logic [31:0]                         req_stamp_ms,
   input  logic signed [23:0]                  req_pos_x_mm,
   input  logic signed [23:0]                  req_pos_y_mm,
   input  logic [15:0]                         req_heading,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_similar,
   output logic [31:0]                         rsp_seen_count,
   output logic [31:0]                         rsp_kept_count,

   input  logic                                csr_we,
   input  logic [pmf_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [pmf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import pmf_pkg::*;

   // Configuration. The distance limit is squared as it is written, so the
   // compare path never multiplies by it.
   logic [31:0] dist_sq_ff;
   logic [15:0] max_heading_ff;
   logic [31:0] max_time_ff;
   limits_type  limits;

   // Input register.
   logic        in_valid_ff;
   logic        in_restart_ff;
   pose_type    in_pose_ff;

   // Result register.
   logic        out_valid_ff;
   logic        out_similar_ff;
   logic [31:0] out_seen_ff;
   logic [31:0] out_kept_ff;

   logic        advance;
   logic        similar;
   ref_type     ref_pose;
   logic [31:0] seen_next;
   logic [31:0] kept_next;
   pose_type    req_pose;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_sq_ff     <= {16'd0, MAX_DISTANCE_RESET} * {16'd0, MAX_DISTANCE_RESET};
         max_heading_ff <= MAX_HEADING_RESET;
         max_time_ff    <= MAX_TIME_DIFF_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_DISTANCE:  dist_sq_ff     <= {16'd0, csr_wdata[15:0]}
                                                 * {16'd0, csr_wdata[15:0]};
            CSR_MAX_HEADING:   max_heading_ff <= csr_wdata[15:0];
            CSR_MAX_TIME_DIFF: max_time_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign limits.dist_sq = dist_sq_ff;
   assign limits.heading = max_heading_ff;
   assign limits.time_ms = max_time_ff;

   // The input register moves on whenever the result register is free or
   // is being emptied in this cycle; the reference is updated in that cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign req_pose.stamp_ms = req_stamp_ms;
   assign req_pose.pos_x_mm = req_pos_x_mm;
   assign req_pose.pos_y_mm = req_pos_y_mm;
   assign req_pose.heading  = req_heading;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_restart_ff <= req_restart;
         in_pose_ff    <= req_pose;
      end
   end

   pmf_compare u_compare (
      .pose     (in_pose_ff),
      .ref_pose (ref_pose),
      .limits   (limits),
      .similar  (similar)
   );

   pmf_track u_track (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .restart   (in_restart_ff),
      .pose      (in_pose_ff),
      .similar   (similar),
      .ref_pose  (ref_pose),
      .seen_next (seen_next),
      .kept_next (kept_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_similar_ff <= similar;
         out_seen_ff    <= seen_next;
         out_kept_ff    <= kept_next;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_similar    = out_similar_ff;
   assign rsp_seen_count = out_seen_ff;
   assign rsp_kept_count = out_kept_ff;

endmodule

// ----- hw/rtl/pmf_checker.sv -----
module pmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_similar,
   input logic [31:0] rsp_seen_count,
   input logic [31:0] rsp_kept_count
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_similar)
         && $stable(rsp_seen_count) && $stable(rsp_kept_count))
      else $error("stalled result changed");

   // Every kept pose was also seen.
   a_kept_le_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept_count <= rsp_seen_count)
      else $error("kept count exceeds seen count");

   // A result always counts its own pose.
   a_seen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seen_count != 32'd0)
      else $error("seen count is zero on a result");

   // A pose that is not similar becomes the reference and is counted as kept.
   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_similar |-> rsp_kept_count != 32'd0)
      else $error("new reference not counted as kept");

endmodule

bind pose_motion_filter pmf_checker u_pmf_checker (.*);

// ----- verif/pose_motion_filter_tb.sv -----
`timescale 1ns / 1ps

module pose_motion_filter_tb;
   import pmf_pkg::*;

   // The configuration port has room for one index past the last register.
   // A write there must leave every limit as it was.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_INDEX_SPARE = 2'd3;

   // A run with no transaction on either channel for this many cycles is hung.
   // The longest legal quiet stretch is the receiver hold-off of HOLD_CYCLES.
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned POSES_PER_PHASE = 255;

   // One request: the restart flag and the pose that goes with it.
   typedef struct packed {
      logic     restart;
      pose_type pose;
   } pose_item_type;

   // One response as the block should report it.
   typedef struct packed {
      logic        similar;
      logic [31:0] seen;
      logic [31:0] kept;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_restart = 1'b0;
   logic [31:0]        req_stamp_ms = '0;
   logic signed [23:0] req_pos_x_mm = '0;
   logic signed [23:0] req_pos_y_mm = '0;
   logic [15:0]        req_heading = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_similar;
   logic [31:0] rsp_seen_count;
   logic [31:0] rsp_kept_count;

   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   pose_motion_filter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .req_stamp_ms   (req_stamp_ms),
      .req_pos_x_mm   (req_pos_x_mm),
      .req_pos_y_mm   (req_pos_y_mm),
      .req_heading    (req_heading),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_similar    (rsp_similar),
      .rsp_seen_count (rsp_seen_count),
      .rsp_kept_count (rsp_kept_count),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Poses waiting to be offered, and verdicts waiting for their response.
   pose_item_type pending_poses[$];
   verdict_type   expected_verdicts[$];

   // The testbench's own copy of the similarity limits. They only change while
   // the block is idle, so the copy is updated as the write is driven.
   logic [15:0] limit_dist = MAX_DISTANCE_RESET;
   logic [15:0] limit_heading = MAX_HEADING_RESET;
   logic [31:0] limit_time = MAX_TIME_DIFF_RESET;

   // The keyframe tracker state as the block should hold it.
   ref_type     anchor = '0;
   logic [31:0] poses_seen = '0;
   logic [31:0] poses_kept = '0;

   int unsigned fail_count = 0;
   int unsigned rsp_count = 0;
   logic        req_taken = 1'b0;
   pose_type    cursor = '0;

   // Judges one accepted pose against the current keyframe and advances the
   // tracker. A pose that is not close enough becomes the new keyframe.
   function automatic verdict_type judge_pose(input pose_item_type item);
      verdict_type verdict;
      logic [31:0] dt;
      longint      dx;
      longint      dy;
      longint      dist_sq;
      longint      limit_sq;
      logic [15:0] dh;
      logic [16:0] abs_dh;
      logic        close;
      if (item.restart) begin
         anchor = '0;
         poses_seen = '0;
         poses_kept = '0;
      end
      if (poses_seen != 32'hFFFF_FFFF) begin
         poses_seen = poses_seen + 32'd1;
      end
      // The time difference wraps, so a pose older than the keyframe looks
      // very far away in time.
      dt = item.pose.stamp_ms - anchor.pose.stamp_ms;
      dx = longint'($signed(item.pose.pos_x_mm)) - longint'($signed(anchor.pose.pos_x_mm));
      dy = longint'($signed(item.pose.pos_y_mm)) - longint'($signed(anchor.pose.pos_y_mm));
      dist_sq = dx * dx + dy * dy;
      limit_sq = longint'(limit_dist) * longint'(limit_dist);
      // The heading difference is read as a signed 16-bit angle; its magnitude
      // reaches 32768 for a half turn.
      dh = item.pose.heading - anchor.pose.heading;
      abs_dh = dh[15] ? (17'h10000 - {1'b0, dh}) : {1'b0, dh};
      close = anchor.valid && (dt <= limit_time) && (dist_sq <= limit_sq) &&
              (abs_dh <= {1'b0, limit_heading});
      if (!close) begin
         anchor.valid = 1'b1;
         anchor.pose = item.pose;
         if (poses_kept != 32'hFFFF_FFFF) begin
            poses_kept = poses_kept + 32'd1;
         end
      end
      verdict.similar = close;
      verdict.seen = poses_seen;
      verdict.kept = poses_kept;
      return verdict;
   endfunction

   // Drives one register write for a single cycle and mirrors it in the
   // testbench's limits. Bits above a register's width are dropped.
   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      case (index)
         CSR_MAX_DISTANCE: limit_dist = value[15:0];
         CSR_MAX_HEADING: limit_heading = value[15:0];
         CSR_MAX_TIME_DIFF: limit_time = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_pose(input logic restart, input logic [31:0] stamp,
                           input int x, input int y, input logic [15:0] heading);
      pose_item_type item;
      item.restart = restart;
      item.pose.stamp_ms = stamp;
      item.pose.pos_x_mm = 24'(x);
      item.pose.pos_y_mm = 24'(y);
      item.pose.heading = heading;
      pending_poses.push_back(item);
   endtask

   // Returns once every pose has been offered and answered, then lets the
   // block's two-stage pipeline settle before the caller touches registers.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_poses.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Picks a new set of limits. Each limit lands on its floor or ceiling now
   // and then; writes to the 16-bit registers carry junk in their upper half.
   task automatic pick_limits();
      logic [15:0] dist_mm;
      logic [15:0] heading;
      logic [31:0] span;
      case ($urandom_range(0, 5))
         0: dist_mm = 16'd0;
         1: dist_mm = 16'hFFFF;
         default: dist_mm = 16'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(0, 5))
         0: heading = 16'd0;
         1: heading = 16'd32768;
         default: heading = 16'($urandom_range(1, 8000));
      endcase
      case ($urandom_range(0, 5))
         0: span = 32'd0;
         1: span = 32'hFFFF_FFFF;
         default: span = $urandom_range(1, 20000);
      endcase
      write_csr(CSR_MAX_DISTANCE, {16'($urandom()), dist_mm});
      write_csr(CSR_MAX_HEADING, {16'($urandom()), heading});
      write_csr(CSR_MAX_TIME_DIFF, span);
      write_csr(CSR_INDEX_SPARE, $urandom());
   endtask

   // Queues a track that wanders around at a pace scaled to the current
   // limits, so it drifts out of range of its keyframe every few poses. Now
   // and then the track restarts, jumps anywhere, stands still, or goes back
   // in time.
   task automatic queue_track(input int unsigned count);
      pose_item_type item;
      int unsigned   pick;
      int unsigned   step_mm;
      int unsigned   step_h;
      int unsigned   step_ms;
      step_mm = limit_dist / 2 + 1;
      step_h = limit_heading / 2 + 1;
      step_ms = limit_time / 3 + 1;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick >= 3 && pick < 9) begin
            cursor.stamp_ms = $urandom();
            cursor.pos_x_mm = 24'($urandom());
            cursor.pos_y_mm = 24'($urandom());
            cursor.heading = 16'($urandom());
         end else if (pick >= 14 && pick < 17) begin
            cursor.stamp_ms = cursor.stamp_ms - $urandom_range(1, 1000);
         end else if (pick < 9 || pick >= 17) begin
            cursor.stamp_ms = cursor.stamp_ms + $urandom_range(0, step_ms);
            cursor.pos_x_mm = cursor.pos_x_mm +
                              24'(int'($urandom_range(0, 2 * step_mm)) - int'(step_mm));
            cursor.pos_y_mm = cursor.pos_y_mm +
                              24'(int'($urandom_range(0, 2 * step_mm)) - int'(step_mm));
            cursor.heading = cursor.heading +
                             16'(int'($urandom_range(0, 2 * step_h)) - int'(step_h));
         end
         item.restart = (pick < 3);
         item.pose = cursor;
         pending_poses.push_back(item);
      end
   endtask

   // Driver: offers queued poses at the falling edge in bursts of random
   // length with random gaps. A pose stays on the bus until it is taken.
   int unsigned   burst_left = 0;
   int unsigned   gap_left = 0;
   pose_item_type next_pose;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_poses.size() > 0) begin
            next_pose = pending_poses[0];
            pending_poses.delete(0);
            req_restart <= next_pose.restart;
            req_stamp_ms <= next_pose.pose.stamp_ms;
            req_pos_x_mm <= next_pose.pose.pos_x_mm;
            req_pos_y_mm <= next_pose.pose.pos_y_mm;
            req_heading <= next_pose.pose.heading;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               // A quarter of the bursts run straight into the next one.
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: cycles through windows of always ready, coin-flip, mostly
   // stalled and mostly ready. Twice during the run it holds off for a long
   // stretch so the pipeline fills and back-pressures the request side.
   int unsigned rx_cycle = 0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;

   always @(negedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if ((holds_done == 0 && rsp_count >= 300) ||
                   (holds_done == 1 && rsp_count >= 1100)) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_cycle[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Monitor: at each rising edge it first records an accepted request and
   // predicts its verdict, then checks an accepted response against the
   // oldest prediction, field by field.
   pose_item_type accepted_pose;
   verdict_type   wanted;

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            accepted_pose.restart = req_restart;
            accepted_pose.pose.stamp_ms = req_stamp_ms;
            accepted_pose.pose.pos_x_mm = req_pos_x_mm;
            accepted_pose.pose.pos_y_mm = req_pos_y_mm;
            accepted_pose.pose.heading = req_heading;
            expected_verdicts.push_back(judge_pose(accepted_pose));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing expected: similar %0d seen %0d kept %0d",
                        $time, rsp_similar, rsp_seen_count, rsp_kept_count);
            end else begin
               wanted = expected_verdicts[0];
               expected_verdicts.delete(0);
               if (rsp_similar !== wanted.similar) begin
                  fail_count++;
                  $display("%0t: similar mismatch: expected %0d, actual %0d",
                           $time, wanted.similar, rsp_similar);
               end
               if (rsp_seen_count !== wanted.seen) begin
                  fail_count++;
                  $display("%0t: seen_count mismatch: expected %0d, actual %0d",
                           $time, wanted.seen, rsp_seen_count);
               end
               if (rsp_kept_count !== wanted.kept) begin
                  fail_count++;
                  $display("%0t: kept_count mismatch: expected %0d, actual %0d",
                           $time, wanted.kept, rsp_kept_count);
               end
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no transaction means a hang.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Default limits: 300 mm, 3641 heading units, 9999000 ms.
      // The first pose has no keyframe to compare with.
      add_pose(1'b0, 32'd1000, 0, 0, 16'd0);
      // Exactly 300 mm away and exactly at the heading limit.
      add_pose(1'b0, 32'd1500, 180, 240, 16'd3641);
      // Just past the distance limit, so it becomes the keyframe.
      add_pose(1'b0, 32'd2000, 181, 240, 16'd0);
      // Exactly at the time limit, heading one unit below zero.
      add_pose(1'b0, 32'd10001000, 181, 240, 16'd65535);
      // One millisecond past the time limit.
      add_pose(1'b0, 32'd10001001, 181, 240, 16'd65535);
      // Older than the keyframe: the wrapped time difference is huge.
      add_pose(1'b0, 32'd10001000, 181, 240, 16'd65535);
      // Restart at the corner of the coordinate range.
      add_pose(1'b1, 32'd5000, -8388608, 8388607, 16'd65500);
      // Heading difference across the wrap point, then at and past the limit.
      add_pose(1'b0, 32'd5001, -8388608, 8388607, 16'd100);
      add_pose(1'b0, 32'd5002, -8388608, 8388607, 16'd3605);
      add_pose(1'b0, 32'd5003, -8388608, 8388607, 16'd3606);
      // A half turn away.
      add_pose(1'b0, 32'd5004, -8388608, 8388607, 16'd36374);
      // Jump to the opposite corner.
      add_pose(1'b0, 32'd5005, 8388607, -8388608, 16'd36374);
      // Restart on a pose that would otherwise be similar.
      add_pose(1'b1, 32'd5005, 8388607, -8388608, 16'd36374);
      add_pose(1'b0, 32'd5006, 8388607, -8388608, 16'd36374);
      wait_idle();

      // Widest limits: any time difference and any heading pass.
      write_csr(CSR_MAX_DISTANCE, 32'h0000_FFFF);
      write_csr(CSR_MAX_HEADING, 32'd32768);
      write_csr(CSR_MAX_TIME_DIFF, 32'hFFFF_FFFF);
      @(posedge clock);
      add_pose(1'b1, 32'd0, 0, 0, 16'd0);
      add_pose(1'b0, 32'hFFFF_FFFF, 65535, 0, 16'd32768);
      add_pose(1'b0, 32'd5, 65536, 0, 16'd0);
      add_pose(1'b0, 32'd4, 1, 0, 16'd32768);
      add_pose(1'b0, 32'd3, -8388608, -8388608, 16'd0);
      wait_idle();

      // Zero limits, with junk above the 16-bit registers: only an identical
      // pose with the same timestamp counts as similar.
      write_csr(CSR_MAX_DISTANCE, 32'hFFFF_0000);
      write_csr(CSR_MAX_HEADING, 32'hFFFF_0000);
      write_csr(CSR_MAX_TIME_DIFF, 32'd0);
      write_csr(CSR_INDEX_SPARE, 32'hFFFF_FFFF);
      @(posedge clock);
      add_pose(1'b1, 32'd77, 8388607, 8388607, 16'd65535);
      add_pose(1'b0, 32'd77, 8388607, 8388607, 16'd65535);
      add_pose(1'b0, 32'd78, 8388607, 8388607, 16'd65535);
      add_pose(1'b0, 32'd78, 8388607, 8388607, 16'd65534);
      wait_idle();

      // Random tracks, each under a fresh set of limits. Every phase waits
      // for the last response before the registers change.
      repeat (RANDOM_PHASES) begin
         pick_limits();
         @(posedge clock);
         queue_track(POSES_PER_PHASE);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         fail_count++;
         $display("%0t: %0d responses never arrived", $time, expected_verdicts.size());
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
